// File: rtl/sphspf_pkg.sv
// ----------------------------------------------------------------------------
// sphspf_pkg
// shared constants, types and helpers of the spiky pressure force unit
// ----------------------------------------------------------------------------
`default_nettype none

package sphspf_pkg;

  localparam int FRAC_BITS = 16;
  localparam int IN_W      = 32;
  localparam int OUT_W     = 48;
  localparam int H_W       = 31;
  localparam int COEFF_W   = 64;
  localparam int MIND_W    = 16;
  localparam int CFG_W     = 64;

  localparam logic [63:0] MAG_CAP = 64'h7FFF_FFFF_FFFF_FFFF;

  typedef enum logic [1:0] {
    CFG_RADIUS = 2'd0,
    CFG_COEFF  = 2'd1,
    CFG_MIND   = 2'd2
  } cfg_idx_t;

  // status of a bit-serial arithmetic unit
  typedef struct packed {
    logic busy;
    logic done;
  } unit_sts_t;

  typedef struct packed {
    logic        ovf;
    logic [63:0] val;
  } clamp_t;

  // product shifted right by the fraction width or by 32, clamped to 2^63-1
  function automatic clamp_t shr_clamp(input logic [127:0] p, input logic by32);
    logic [127:0] sh;
    clamp_t       c;
    sh    = by32 ? (p >> 32) : (p >> FRAC_BITS);
    c.ovf = (sh[127:63] != '0);
    c.val = c.ovf ? MAG_CAP : sh[63:0];
    return c;
  endfunction

endpackage

`default_nettype wire

// File: rtl/sphspf_in_if.sv
// ----------------------------------------------------------------------------
// sphspf_in_if
// neighbor channel: query and neighbor particle data per transaction
// ----------------------------------------------------------------------------
`default_nettype none

interface sphspf_in_if;
  import sphspf_pkg::*;

  logic                    valid;
  logic                    ready;
  logic signed [IN_W-1:0]  query_x;
  logic signed [IN_W-1:0]  query_y;
  logic signed [IN_W-1:0]  query_pressure;
  logic signed [IN_W-1:0]  neighbor_x;
  logic signed [IN_W-1:0]  neighbor_y;
  logic        [IN_W-1:0]  neighbor_mass;
  logic signed [IN_W-1:0]  neighbor_pressure;
  logic signed [IN_W-1:0]  neighbor_density;
  logic                    last;

  modport source (output valid, query_x, query_y, query_pressure, neighbor_x, neighbor_y,
                  neighbor_mass, neighbor_pressure, neighbor_density, last,
                  input ready);
  modport sink   (input valid, query_x, query_y, query_pressure, neighbor_x, neighbor_y,
                  neighbor_mass, neighbor_pressure, neighbor_density, last,
                  output ready);
endinterface

`default_nettype wire

// File: rtl/sphspf_out_if.sv
// ----------------------------------------------------------------------------
// sphspf_out_if
// force channel: one saturated force vector per transaction
// ----------------------------------------------------------------------------
`default_nettype none

interface sphspf_out_if;
  import sphspf_pkg::*;

  logic                    valid;
  logic                    ready;
  logic signed [OUT_W-1:0] force_x;
  logic signed [OUT_W-1:0] force_y;
  logic                    saturated;

  modport source (output valid, force_x, force_y, saturated, input ready);
  modport sink   (input valid, force_x, force_y, saturated, output ready);
endinterface

`default_nettype wire

// File: rtl/sphspf_mul.sv
// ----------------------------------------------------------------------------
// sphspf_mul
// bit-serial 64x64 unsigned multiplier, one multiplier bit per cycle
// ----------------------------------------------------------------------------
`default_nettype none

module sphspf_mul (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  start,
  input  wire logic [63:0]           a,
  input  wire logic [63:0]           b,
  output sphspf_pkg::unit_sts_t      sts,
  output logic      [127:0]          prod
);
  import sphspf_pkg::*;

  logic [63:0] a_r;
  logic [63:0] hi_r;
  logic [63:0] lo_r;
  logic [5:0]  cnt_r;
  logic        busy_r;
  logic        done_r;
  logic [64:0] sum;

  assign sum = {1'b0, hi_r} + (lo_r[0] ? {1'b0, a_r} : 65'd0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
      end else if (busy_r && cnt_r == 6'd63) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      a_r   <= a;
      hi_r  <= '0;
      lo_r  <= b;
      cnt_r <= '0;
    end else if (busy_r) begin
      hi_r  <= sum[64:1];
      lo_r  <= {sum[0], lo_r[63:1]};
      cnt_r <= cnt_r + 6'd1;
    end
  end

  assign sts.busy = busy_r;
  assign sts.done = done_r;
  assign prod     = {hi_r, lo_r};

endmodule

`default_nettype wire

// File: rtl/sphspf_div.sv
// ----------------------------------------------------------------------------
// sphspf_div
// restoring 64/64 unsigned divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
`default_nettype none

module sphspf_div (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  start,
  input  wire logic [63:0]           num,
  input  wire logic [63:0]           den,
  output sphspf_pkg::unit_sts_t      sts,
  output logic      [63:0]           quo
);
  import sphspf_pkg::*;

  logic [63:0] d_r;
  logic [63:0] rem_r;
  logic [63:0] q_r;
  logic [5:0]  cnt_r;
  logic        busy_r;
  logic        done_r;
  logic [64:0] rsh;
  logic [64:0] diff;
  logic        ge;

  assign rsh  = {rem_r, q_r[63]};
  assign diff = rsh - {1'b0, d_r};
  assign ge   = (rsh >= {1'b0, d_r});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
      end else if (busy_r && cnt_r == 6'd63) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      d_r   <= den;
      rem_r <= '0;
      q_r   <= num;
      cnt_r <= '0;
    end else if (busy_r) begin
      rem_r <= ge ? diff[63:0] : rsh[63:0];
      q_r   <= {q_r[62:0], ge};
      cnt_r <= cnt_r + 6'd1;
    end
  end

  assign sts.busy = busy_r;
  assign sts.done = done_r;
  assign quo      = q_r;

endmodule

`default_nettype wire

// File: rtl/sph_spiky_pressure_force_unit.sv
// ----------------------------------------------------------------------------
// sph_spiky_pressure_force_unit
// 2d sph pressure force on one query particle, spiky kernel, q16.16
// ----------------------------------------------------------------------------
// usage:
//   in_ch carries one neighbor per transaction together with the query
//   particle; neighbors of one query follow back to back, the last one
//   flagged with last. out_ch gives one force transaction per last neighbor:
//   the negated accumulated sum, clamped to 48 bits, with a saturation flag.
//   cfg_we/cfg_index/cfg_wdata write radius, kernel coefficient and minimum
//   distance; write only while the unit is idle.
// neighbor processing:
//   a skipped neighbor fails the density or box test, or is rejected after
//   the square root (two squares and the root). a contributing neighbor
//   makes 8 passes through the shared bit-serial multiplier, 3 through the
//   bit-serial divider and one through the square root, one result bit per
//   cycle in each unit; in_ch takes a new neighbor only in the idle state.
// reset: synchronous, clears accumulators, flags and the output valid bit
//   and loads the default register values.
// stall: a finished force waits in the output register; new neighbors are
//   taken meanwhile and only the next force waits for the register to free.
// ----------------------------------------------------------------------------
`default_nettype none

module sph_spiky_pressure_force_unit (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  sphspf_in_if.sink                    in_ch,
  sphspf_out_if.source                 out_ch,
  input  wire logic                    cfg_we,
  input  wire logic [1:0]              cfg_index,
  input  wire logic [sphspf_pkg::CFG_W-1:0] cfg_wdata
);
  import sphspf_pkg::*;

  typedef enum logic [14:0] {
    S_IDLE = 15'h0001,
    S_SQX  = 15'h0002,
    S_SQY  = 15'h0004,
    S_SQRT = 15'h0008,
    S_HELP = 15'h0010,
    S_K    = 15'h0020,
    S_W    = 15'h0040,
    S_MH   = 15'h0080,
    S_S    = 15'h0100,
    S_UX   = 15'h0200,
    S_UY   = 15'h0400,
    S_TX   = 15'h0800,
    S_TY   = 15'h1000,
    S_FIN  = 15'h2000,
    S_SPARE = 15'h4000
  } state_t;

  localparam logic signed [64:0] SUM_MAX = {1'b0, MAG_CAP};
  localparam logic signed [64:0] SUM_MIN = -SUM_MAX;
  localparam logic signed [63:0] F_MAX   = 64'sh0000_7FFF_FFFF_FFFF;
  localparam logic signed [63:0] F_MIN   = -64'sh0000_8000_0000_0000;

  // saturating accumulate, flag in the top bit
  function automatic logic [64:0] sat_add(input logic signed [63:0] a,
                                          input logic signed [63:0] b);
    logic signed [64:0] s;
    logic        [64:0] r;
    s = 65'(a) + 65'(b);
    if (s > SUM_MAX)      r = {1'b1, MAG_CAP};
    else if (s < SUM_MIN) r = {1'b1, SUM_MIN[63:0]};
    else                  r = {1'b0, s[63:0]};
    return r;
  endfunction

  // negate and clamp to the output width, flag in the top bit
  function automatic logic [OUT_W:0] emit(input logic signed [63:0] sum);
    logic signed [63:0] f;
    logic        [OUT_W:0] r;
    f = -sum;
    if (f > F_MAX)      r = {1'b1, F_MAX[OUT_W-1:0]};
    else if (f < F_MIN) r = {1'b1, F_MIN[OUT_W-1:0]};
    else                r = {1'b0, f[OUT_W-1:0]};
    return r;
  endfunction

  // configuration registers
  logic [H_W-1:0]     radius_r;
  logic [COEFF_W-1:0] coeff_r;
  logic [MIND_W-1:0]  mind_r;

  // control
  state_t state_r, state_nxt;
  logic   issued_r;

  // accumulators
  logic signed [63:0] sum_x_r;
  logic signed [63:0] sum_y_r;
  logic               ovf_r;

  // per-neighbor operands
  logic [H_W-1:0]  ax_r, ay_r;
  logic            negx_r, negy_r, ppos_r, last_r;
  logic [32:0]     pmag_r;
  logic [30:0]     rho_r;
  logic [31:0]     mass_r;
  logic [31:0]     r_r;
  logic [H_W-1:0]  hm_r;
  logic [48:0]     helper_r;
  logic [45:0]     k_r;
  logic [62:0]     w_r, mh_r, s_r;
  logic [16:0]     ux_r, uy_r;

  // square root
  logic [63:0] sq_r;
  logic [31:0] root_r;
  logic [33:0] srem_r;
  logic [4:0]  scnt_r;
  logic [35:0] rem2, trial;
  logic        sge;
  logic [31:0] r_fin;
  logic        r_ok;

  // front end
  logic signed [32:0] dx, dy, ps;
  logic [32:0]        ax, ay;
  logic               pre_ok, acc;

  // shared units
  logic        mul_start, div_start;
  logic [63:0] mul_a, mul_b, div_n, div_d;
  unit_sts_t   mul_sts, div_sts;
  logic [127:0] mul_prod;
  logic [63:0]  div_q;
  clamp_t       c16, c32;
  logic         is_mul, is_div, unit_done;
  logic [63:0]  tmag, tval;
  logic         tflip;
  logic [64:0]  acc_x, acc_y;
  logic [OUT_W:0] ex, ey;
  logic         out_free;

  // out register
  logic                    out_valid_r;
  logic signed [OUT_W-1:0] fx_r, fy_r;
  logic                    fsat_r;

  sphspf_mul u_mul (
    .clk, .rst_n, .start(mul_start), .a(mul_a), .b(mul_b), .sts(mul_sts), .prod(mul_prod)
  );

  sphspf_div u_div (
    .clk, .rst_n, .start(div_start), .num(div_n), .den(div_d), .sts(div_sts), .quo(div_q)
  );

  // differences and early rejection
  assign dx     = 33'(in_ch.query_x) - 33'(in_ch.neighbor_x);
  assign dy     = 33'(in_ch.query_y) - 33'(in_ch.neighbor_y);
  assign ps     = 33'(in_ch.query_pressure) + 33'(in_ch.neighbor_pressure);
  assign ax     = dx[32] ? 33'(-dx) : 33'(dx);
  assign ay     = dy[32] ? 33'(-dy) : 33'(dy);
  assign pre_ok = !in_ch.neighbor_density[31] && (in_ch.neighbor_density != '0) &&
                  (ax <= {2'b0, radius_r}) && (ay <= {2'b0, radius_r});
  assign acc    = in_ch.valid && in_ch.ready;

  assign in_ch.ready = (state_r == S_IDLE);

  // one root bit per cycle
  assign rem2  = {srem_r, sq_r[63:62]};
  assign trial = {2'b0, root_r, 2'b01};
  assign sge   = (rem2 >= trial);
  assign r_fin = {root_r[30:0], sge};
  assign r_ok  = (r_fin > {16'b0, mind_r}) && (r_fin <= {1'b0, radius_r});

  assign is_mul = (state_r == S_SQX) || (state_r == S_SQY) || (state_r == S_K) ||
                  (state_r == S_W) || (state_r == S_MH) || (state_r == S_S) ||
                  (state_r == S_TX) || (state_r == S_TY);
  assign is_div = (state_r == S_HELP) || (state_r == S_UX) || (state_r == S_UY);
  assign mul_start = is_mul && !issued_r;
  assign div_start = is_div && !issued_r;
  assign unit_done = issued_r && (is_mul ? mul_sts.done : div_sts.done);

  assign c16 = shr_clamp(mul_prod, 1'b0);
  assign c32 = shr_clamp(mul_prod, 1'b1);

  // term sign: gradient carries a negative coefficient
  assign tmag  = c16.val;
  assign tflip = (state_r == S_TX) ? (negx_r == ppos_r) : (negy_r == ppos_r);
  assign tval  = tflip ? (64'd0 - tmag) : tmag;
  assign acc_x = sat_add(sum_x_r, tval);
  assign acc_y = sat_add(sum_y_r, tval);

  assign ex       = emit(sum_x_r);
  assign ey       = emit(sum_y_r);
  assign out_free = !out_valid_r || out_ch.ready;

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    div_n = '0;
    div_d = 64'd1;
    unique case (state_r)
      S_SQX:  begin mul_a = 64'(ax_r);     mul_b = 64'(ax_r); end
      S_SQY:  begin mul_a = 64'(ay_r);     mul_b = 64'(ay_r); end
      S_K:    begin mul_a = 64'(hm_r);     mul_b = 64'(hm_r); end
      S_W:    begin mul_a = coeff_r;       mul_b = 64'(k_r); end
      S_MH:   begin mul_a = 64'(mass_r);   mul_b = 64'(helper_r); end
      S_S:    begin mul_a = 64'(mh_r);     mul_b = 64'(w_r); end
      S_TX:   begin mul_a = 64'(s_r);      mul_b = 64'(ux_r); end
      S_TY:   begin mul_a = 64'(s_r);      mul_b = 64'(uy_r); end
      S_HELP: begin
        div_n = 64'({pmag_r, FRAC_BITS'(0)});
        div_d = 64'({rho_r, 1'b0});
      end
      S_UX:   begin div_n = 64'({ax_r, FRAC_BITS'(0)}); div_d = 64'(r_r); end
      S_UY:   begin div_n = 64'({ay_r, FRAC_BITS'(0)}); div_d = 64'(r_r); end
      default: ;
    endcase
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: if (acc) begin
        if (pre_ok)             state_nxt = S_SQX;
        else if (in_ch.last)    state_nxt = S_FIN;
      end
      S_SQX:  if (unit_done) state_nxt = S_SQY;
      S_SQY:  if (unit_done) state_nxt = S_SQRT;
      S_SQRT: if (scnt_r == 5'd31) begin
        if (r_ok)        state_nxt = S_HELP;
        else if (last_r) state_nxt = S_FIN;
        else             state_nxt = S_IDLE;
      end
      S_HELP: if (unit_done) state_nxt = S_K;
      S_K:    if (unit_done) state_nxt = S_W;
      S_W:    if (unit_done) state_nxt = S_MH;
      S_MH:   if (unit_done) state_nxt = S_S;
      S_S:    if (unit_done) state_nxt = S_UX;
      S_UX:   if (unit_done) state_nxt = S_UY;
      S_UY:   if (unit_done) state_nxt = S_TX;
      S_TX:   if (unit_done) state_nxt = S_TY;
      S_TY:   if (unit_done) state_nxt = last_r ? S_FIN : S_IDLE;
      S_FIN:  if (out_free)  state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // control, accumulators, configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      issued_r    <= 1'b0;
      sum_x_r     <= '0;
      sum_y_r     <= '0;
      ovf_r       <= 1'b0;
      out_valid_r <= 1'b0;
      radius_r    <= H_W'(65536);
      coeff_r     <= 64'd41013916537;
      mind_r      <= MIND_W'(7);
    end else begin
      state_r <= state_nxt;
      if (mul_start || div_start) issued_r <= 1'b1;
      else if (unit_done)         issued_r <= 1'b0;

      if (cfg_we) begin
        unique case (cfg_index)
          CFG_RADIUS: radius_r <= cfg_wdata[H_W-1:0];
          CFG_COEFF:  coeff_r  <= cfg_wdata;
          CFG_MIND:   mind_r   <= cfg_wdata[MIND_W-1:0];
          default: ;
        endcase
      end

      if (unit_done) begin
        if ((state_r == S_W && c32.ovf) || (state_r == S_MH && c16.ovf) ||
            (state_r == S_S && c16.ovf)) begin
          ovf_r <= 1'b1;
        end
        if (state_r == S_TX) begin
          sum_x_r <= acc_x[63:0];
          if (c16.ovf || acc_x[64]) ovf_r <= 1'b1;
        end
        if (state_r == S_TY) begin
          sum_y_r <= acc_y[63:0];
          if (c16.ovf || acc_y[64]) ovf_r <= 1'b1;
        end
      end

      if (out_ch.ready) out_valid_r <= 1'b0;
      if (state_r == S_FIN && out_free) begin
        out_valid_r <= 1'b1;
        sum_x_r     <= '0;
        sum_y_r     <= '0;
        ovf_r       <= 1'b0;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (acc) begin
      ax_r   <= ax[H_W-1:0];
      ay_r   <= ay[H_W-1:0];
      negx_r <= dx[32];
      negy_r <= dy[32];
      ppos_r <= !ps[32];
      pmag_r <= ps[32] ? 33'(-ps) : 33'(ps);
      rho_r  <= in_ch.neighbor_density[30:0];
      mass_r <= in_ch.neighbor_mass;
      last_r <= in_ch.last;
    end
    if (unit_done) begin
      unique case (state_r)
        S_SQX: sq_r <= mul_prod[63:0];
        S_SQY: begin
          sq_r   <= sq_r + mul_prod[63:0];
          root_r <= '0;
          srem_r <= '0;
          scnt_r <= '0;
        end
        S_HELP: helper_r <= div_q[48:0];
        S_K:    k_r      <= c16.val[45:0];
        S_W:    w_r      <= c32.val[62:0];
        S_MH:   mh_r     <= c16.val[62:0];
        S_S:    s_r      <= c16.val[62:0];
        S_UX:   ux_r     <= div_q[16:0];
        S_UY:   uy_r     <= div_q[16:0];
        default: ;
      endcase
    end
    if (state_r == S_SQRT) begin
      srem_r <= sge ? 34'(rem2 - trial) : rem2[33:0];
      root_r <= r_fin;
      sq_r   <= {sq_r[61:0], 2'b00};
      scnt_r <= scnt_r + 5'd1;
      if (scnt_r == 5'd31) begin
        r_r  <= r_fin;
        hm_r <= radius_r - r_fin[H_W-1:0];
      end
    end
    if (state_r == S_FIN && out_free) begin
      fx_r   <= ex[OUT_W-1:0];
      fy_r   <= ey[OUT_W-1:0];
      fsat_r <= ovf_r | ex[OUT_W] | ey[OUT_W];
    end
  end

  assign out_ch.valid     = out_valid_r;
  assign out_ch.force_x   = fx_r;
  assign out_ch.force_y   = fy_r;
  assign out_ch.saturated = fsat_r;

  // a result is loaded only from the finish state
  a_out_from_fin: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_FIN))
    else $error("force loaded outside finish state");

  // accumulators are cleared when a force is loaded
  a_clear_after_emit: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_FIN && out_free) |=> (sum_x_r == '0 && sum_y_r == '0 && !ovf_r))
    else $error("accumulators not cleared after force");

  // a unit is never restarted while it runs
  a_no_restart: assert property (@(posedge clk) disable iff (!rst_n)
    !(mul_start && mul_sts.busy) && !(div_start && div_sts.busy))
    else $error("arithmetic unit restarted while busy");

  // no neighbor is taken while a previous one is in flight
  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (mul_sts.busy || div_sts.busy) |-> !in_ch.ready)
    else $error("neighbor accepted during computation");

endmodule

`default_nettype wire

// File: tb/sph_spiky_pressure_force_unit_tb.sv
// ----------------------------------------------------------------------------
// sph_spiky_pressure_force_unit_tb
// self-checking bench: neighbor streams with random handshakes, forces
// compared against a bit-exact fixed-point predictor in a small scoreboard
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sph_spiky_pressure_force_unit_tb;
  import sphspf_pkg::*;

  localparam logic [1:0] CFG_UNUSED = 2'd3;     // index outside the register map
  localparam longint unsigned CYCLE_LIMIT = 64'd20_000_000;
  localparam logic signed [63:0] SUM_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
  localparam logic signed [63:0] F_MAX = 64'sh7FFF_FFFF_FFFF;
  localparam logic signed [63:0] F_MIN = -64'sh8000_0000_0000;

  // one neighbor transaction
  typedef struct {
    logic signed [31:0] qx, qy, qp;
    logic signed [31:0] nx, ny;
    logic [31:0]        mass;
    logic signed [31:0] np, rho;
    logic               last;
  } nbr_t;

  // one force transaction
  typedef struct {
    logic signed [47:0] fx, fy;
    logic               sat;
  } force_t;

  // scoreboard: mirrors registers and accumulators, queues expected forces
  class force_board;
    logic [30:0] radius;
    logic [63:0] coeff;
    logic [15:0] mind;
    logic signed [63:0] acc_x, acc_y;
    logic ovf;
    force_t pending[$];
    int errors;

    function void reset_state();
      radius = 31'd65536;
      coeff = 64'd41013916537;
      mind = 16'd7;
      acc_x = 0;
      acc_y = 0;
      ovf = 0;
      pending.delete();
      errors = 0;
    endfunction

    function void write_reg(logic [1:0] idx, logic [63:0] v);
      case (idx)
        CFG_RADIUS: radius = v[30:0];
        CFG_COEFF:  coeff = v;
        CFG_MIND:   mind = v[15:0];
        default: ;
      endcase
    endfunction

    // (a*b) >> sh, clamped to 2^63-1
    function logic [63:0] mul_clamp(logic [63:0] a, logic [63:0] b, int sh);
      logic [127:0] p;
      p = (128'(a) * 128'(b)) >> sh;
      if (p > 128'(MAG_CAP)) begin
        ovf = 1;
        return MAG_CAP;
      end
      return p[63:0];
    endfunction

    function logic [63:0] root(logic [63:0] v);
      logic [63:0] res, t;
      res = 0;
      for (int b = 32; b >= 0; b--) begin
        t = res | (64'd1 << b);
        if (128'(t) * 128'(t) <= 128'(v)) res = t;
      end
      return res;
    endfunction

    function logic signed [63:0] acc_add(logic signed [63:0] a, logic signed [63:0] b);
      logic signed [64:0] t;
      t = 65'(a) + 65'(b);
      if (t > 65'(SUM_MAX)) begin
        ovf = 1;
        return SUM_MAX;
      end
      if (t < -65'(SUM_MAX)) begin
        ovf = 1;
        return -SUM_MAX;
      end
      return t[63:0];
    endfunction

    function logic signed [47:0] clip48(logic signed [63:0] s, inout logic sat);
      logic signed [63:0] f;
      f = -s;
      if (f > F_MAX) begin f = F_MAX; sat = 1; end
      if (f < F_MIN) begin f = F_MIN; sat = 1; end
      return f[47:0];
    endfunction

    // accepted neighbor: accumulate its term, queue a force on last
    function void note_neighbor(nbr_t n);
      logic signed [63:0] dx, dy, ps, rho, stx, sty;
      logic [63:0] ax, ay, r, pm, helper, hm, k, w, mh, s, ux, uy;
      logic neg;
      force_t e;
      dx = $signed(n.qx) - $signed(n.nx);
      dy = $signed(n.qy) - $signed(n.ny);
      ps = $signed(n.qp) + $signed(n.np);
      rho = n.rho;
      ax = dx < 0 ? -dx : dx;
      ay = dy < 0 ? -dy : dy;
      if (rho > 0 && ax <= radius && ay <= radius) begin
        r = root(ax * ax + ay * ay);
        if (r > mind && r <= radius) begin
          pm = ps < 0 ? -ps : ps;
          helper = (pm << FRAC_BITS) / (64'd2 * rho);
          hm = radius - r;
          k = (hm * hm) >> FRAC_BITS;
          w = mul_clamp(coeff, k, 32);
          mh = mul_clamp(n.mass, helper, FRAC_BITS);
          s = mul_clamp(mh, w, FRAC_BITS);
          ux = (ax << FRAC_BITS) / r;
          uy = (ay << FRAC_BITS) / r;
          stx = mul_clamp(s, ux, FRAC_BITS);
          sty = mul_clamp(s, uy, FRAC_BITS);
          // negative kernel coefficient flips the direction
          neg = ps >= 0;
          if ((dx < 0) == neg) stx = -stx;
          if ((dy < 0) == neg) sty = -sty;
          acc_x = acc_add(acc_x, stx);
          acc_y = acc_add(acc_y, sty);
        end
      end
      if (n.last) begin
        e.sat = ovf;
        e.fx = clip48(acc_x, e.sat);
        e.fy = clip48(acc_y, e.sat);
        pending.push_back(e);
        acc_x = 0;
        acc_y = 0;
        ovf = 0;
      end
    endfunction

    function void check_force(force_t got);
      force_t e;
      if (pending.size() == 0) begin
        $error("force transaction with nothing expected");
        errors++;
        return;
      end
      e = pending.pop_front();
      if (got.fx !== e.fx) begin
        $error("force_x expected %0d actual %0d", e.fx, got.fx);
        errors++;
      end
      if (got.fy !== e.fy) begin
        $error("force_y expected %0d actual %0d", e.fy, got.fy);
        errors++;
      end
      if (got.sat !== e.sat) begin
        $error("saturated expected %0b actual %0b", e.sat, got.sat);
        errors++;
      end
    endfunction
  endclass

  logic clk = 0;
  logic rst_n = 0;
  logic cfg_we = 0;
  logic [1:0] cfg_index = '0;
  logic [CFG_W-1:0] cfg_wdata = '0;

  sphspf_in_if in_ch ();
  sphspf_out_if out_ch ();

  sph_spiky_pressure_force_unit dut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  always begin
    #1 clk = 1;
    #1 clk = 0;
  end

  force_board board = new();
  bit send_gaps = 1;         // sender idles at random
  bit recv_stalls = 1;       // receiver stalls at random
  bit hold_req = 0;          // ask the receiver for a long hold-off
  longint unsigned cycles = 0;

  // cycle limit
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // receiver: ready changes on the falling edge, long hold counted here
  initial begin
    int hold_left;
    hold_left = 0;
    out_ch.ready = 0;
    forever begin
      @(negedge clk);
      if (hold_req && hold_left == 0) begin
        hold_left = 3000;
        hold_req = 0;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready <= 0;
      end else begin
        out_ch.ready <= recv_stalls ? ($urandom_range(99) >= 13) : 1'b1;
      end
    end
  end

  // force transactions checked on the rising edge
  always @(posedge clk) begin
    force_t got;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      got.fx = out_ch.force_x;
      got.fy = out_ch.force_y;
      got.sat = out_ch.saturated;
      board.check_force(got);
    end
  end

  // neighbor transaction: drive at the falling edge, hold until accepted
  task automatic send_nbr(nbr_t n);
    @(negedge clk);
    while (send_gaps && $urandom_range(99) < 13) begin
      in_ch.valid <= 0;
      @(negedge clk);
    end
    in_ch.valid <= 1;
    in_ch.query_x <= n.qx;
    in_ch.query_y <= n.qy;
    in_ch.query_pressure <= n.qp;
    in_ch.neighbor_x <= n.nx;
    in_ch.neighbor_y <= n.ny;
    in_ch.neighbor_mass <= n.mass;
    in_ch.neighbor_pressure <= n.np;
    in_ch.neighbor_density <= n.rho;
    in_ch.last <= n.last;
    do @(posedge clk); while (!in_ch.ready);
    board.note_neighbor(n);
  endtask

  // register write while idle
  task automatic write_cfg(logic [1:0] idx, logic [63:0] v);
    @(negedge clk);
    cfg_we <= 1;
    cfg_index <= idx;
    cfg_wdata <= v;
    @(negedge clk);
    cfg_we <= 0;
    board.write_reg(idx, v);
  endtask

  // drop valid and wait for every queued force plus a settling margin
  task automatic drain();
    @(negedge clk);
    in_ch.valid <= 0;
    wait (board.pending.size() == 0);
    repeat (1000) @(posedge clk);
  endtask

  function automatic nbr_t mk(int qx, int qy, int qp, int nx, int ny,
                              int unsigned m, int np, int rho, bit lst);
    nbr_t n;
    n.qx = qx; n.qy = qy; n.qp = qp;
    n.nx = nx; n.ny = ny; n.mass = m;
    n.np = np; n.rho = rho; n.last = lst;
    return n;
  endfunction

  // neighbor near the query: offset mostly within the radius
  function automatic nbr_t rand_nbr(bit lst);
    nbr_t n;
    logic [31:0] hr, ox, oy;
    n.qx = $urandom();
    n.qy = $urandom();
    if ($urandom_range(3) == 0) begin
      n.qx = $urandom_range(1) ? 32'h7FFF_FFFF : 32'h8000_0000;
    end
    hr = board.radius;
    if ($urandom_range(9) == 0) hr = hr + (hr >> 2);   // some just outside
    ox = $urandom_range(hr);
    oy = $urandom_range(hr);
    if ($urandom_range(3) == 0) oy = $urandom_range(hr >> 3);
    n.nx = $urandom_range(1) ? n.qx - ox : n.qx + ox;
    n.ny = $urandom_range(1) ? n.qy - oy : n.qy + oy;
    n.mass = $urandom_range(3) == 0 ? $urandom() : $urandom_range(32'h0004_0000);
    n.qp = $urandom_range(3) == 0 ? $urandom() : $signed($urandom_range(32'h0010_0000))
           - 32'sh0008_0000;
    n.np = $urandom_range(3) == 0 ? $urandom() : $signed($urandom_range(32'h0010_0000))
           - 32'sh0008_0000;
    case ($urandom_range(9))
      0: n.rho = -$signed($urandom_range(32'h7FFF_FFFF));
      1: n.rho = 0;
      2: n.rho = $urandom_range(32'h7FFF_FFFF, 1);
      default: n.rho = $urandom_range(32'h0008_0000, 32'h0000_1000);
    endcase
    n.last = lst;
    return n;
  endfunction

  function automatic nbr_t noise_nbr(bit lst);
    nbr_t n;
    n.qx = $urandom(); n.qy = $urandom(); n.qp = $urandom();
    n.nx = $urandom(); n.ny = $urandom(); n.mass = $urandom();
    n.np = $urandom(); n.rho = $urandom(); n.last = lst;
    return n;
  endfunction

  task automatic random_phase(int count);
    nbr_t n;
    bit lst;
    for (int i = 0; i < count; i++) begin
      lst = (i == count - 1) || ($urandom_range(4) == 0);
      n = ($urandom_range(99) < 15) ? noise_nbr(lst) : rand_nbr(lst);
      send_nbr(n);
    end
  endtask

  initial begin
    board.reset_state();
    in_ch.valid = 0;
    in_ch.query_x = 0; in_ch.query_y = 0; in_ch.query_pressure = 0;
    in_ch.neighbor_x = 0; in_ch.neighbor_y = 0; in_ch.neighbor_mass = 0;
    in_ch.neighbor_pressure = 0; in_ch.neighbor_density = 0; in_ch.last = 0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1;

    // directed part, reset registers: radius 1.0, minimum distance 7
    send_nbr(mk(0, 0, 32'h0001_0000, 32'h0000_8000, 32'h0000_4000, 32'h0001_0000,
                32'h0001_0000, 32'h0001_0000, 1));
    send_nbr(mk(0, 0, 32'h0001_0000, 32'h0001_0000, 0, 32'h0001_0000,     // r equals h
                32'h0001_0000, 32'h0001_0000, 0));
    send_nbr(mk(0, 0, 32'h0001_0000, 32'h0001_0001, 0, 32'h0001_0000,     // box reject
                32'h0001_0000, 32'h0001_0000, 0));
    send_nbr(mk(0, 0, 32'h0001_0000, 32'h0000_B600, 32'h0000_B600, 32'h0001_0000,
                32'h0001_0000, 32'h0001_0000, 1));                        // r above h
    send_nbr(mk(0, 0, 5, 7, 0, 32'hFFFF_FFFF, 5, 32'h0001_0000, 0));        // too close
    send_nbr(mk(0, 0, 5, 8, 0, 32'hFFFF_FFFF, 5, 1, 1));                    // just outside it
    send_nbr(mk(0, 0, 32'h0001_0000, 32'h0000_4000, 0, 32'h0001_0000,
                32'h0001_0000, 0, 0));                                    // zero density
    send_nbr(mk(0, 0, 32'h0001_0000, 32'h0000_4000, 0, 32'h0001_0000,
                32'h0001_0000, 32'h8000_0000, 1));                        // negative density
    send_nbr(mk(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_C000,
                32'h8000_2000, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 1, 0));      // huge term
    send_nbr(mk(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_3000,
                32'h7FFF_E000, 32'hFFFF_FFFF, 32'h8000_0000, 1, 0));
    send_nbr(mk(0, 0, 32'h8000_0000, 32'hFFFF_C000, 32'h0000_2000, 32'hFFFF_FFFF,
                32'h8000_0000, 32'h7FFF_FFFF, 1));                        // negative pressure
    send_nbr(mk(0, 0, 0, 32'h0000_4000, 32'hFFFF_C000, 32'h0001_0000, 0,
                32'h0001_0000, 1));                                       // zero pressure
    send_nbr(mk(32'h7FFF_FFFF, 0, 0, 32'h8000_0000, 0, 0, 0, 0, 1));      // largest delta
    drain();

    // registers at the extremes: widest radius, largest coefficient
    write_cfg(CFG_RADIUS, 64'h7FFF_FFFF);
    write_cfg(CFG_COEFF, 64'hFFFF_FFFF_FFFF_FFFF);
    write_cfg(CFG_MIND, 64'd0);
    write_cfg(CFG_UNUSED, 64'hFFFF_FFFF_FFFF_FFFF);
    send_nbr(mk(0, 0, 32'h7FFF_FFFF, 1, 0, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 1, 0));
    send_nbr(mk(0, 0, 32'h7FFF_FFFF, 1, 1, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 1, 1));
    random_phase(250);
    drain();

    // small radius, no idling on either side for a long stretch
    send_gaps = 0;
    recv_stalls = 0;
    write_cfg(CFG_RADIUS, 64'd1);
    write_cfg(CFG_COEFF, 64'd0);
    write_cfg(CFG_MIND, 64'd0);
    random_phase(150);
    drain();
    write_cfg(CFG_RADIUS, 64'h0004_0000);
    write_cfg(CFG_COEFF, 64'd41013916537 >> 10);
    random_phase(250);
    drain();

    // receiver holds off while neighbors keep coming
    send_gaps = 1;
    recv_stalls = 1;
    write_cfg(CFG_RADIUS, 64'h0001_0000);
    write_cfg(CFG_COEFF, 64'd41013916537);
    write_cfg(CFG_MIND, 64'hFFFF);
    hold_req = 1;
    random_phase(300);
    drain();

    write_cfg(CFG_MIND, 64'd7);
    write_cfg(CFG_RADIUS, 64'h0010_0000);
    write_cfg(CFG_COEFF, 64'd41013916537 >> 8);
    random_phase(350);
    drain();

    write_cfg(CFG_RADIUS, 64'h0100_0000);
    write_cfg(CFG_COEFF, $urandom());
    write_cfg(CFG_MIND, $urandom_range(16'hFFFF));
    hold_req = 1;
    random_phase(340);
    drain();

    if (board.pending.size() == 0 && board.errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

// File: filelist.f
rtl/sphspf_pkg.sv
rtl/sphspf_in_if.sv
rtl/sphspf_out_if.sv
rtl/sphspf_mul.sv
rtl/sphspf_div.sv
rtl/sph_spiky_pressure_force_unit.sv
tb/sph_spiky_pressure_force_unit_tb.sv
